// File: rtl/pipc_pkg.sv
`timescale 1ns / 1ps
package pipc_pkg;

  localparam int unsigned MAX_VERTICES = 256;
  localparam int unsigned ADDR_W       = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned COORD_W      = 31;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;
  localparam int unsigned MIN_POLY     = 3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              pt_load;
    logic [ADDR_W-1:0] rd_o_addr;
    logic [ADDR_W-1:0] rd_a_addr;
  } cmd_t;

  typedef struct packed {
    logic cross_neg;
    logic cross_pos;
  } sts_t;

endpackage

// File: rtl/pipc_dp.sv
`timescale 1ns / 1ps
module pipc_dp (
  input  logic                                   clk_i,
  input  pipc_pkg::cmd_t                         cmd_i,
  input  logic signed [pipc_pkg::COORD_W-1:0]    coord_x_i,
  input  logic signed [pipc_pkg::COORD_W-1:0]    coord_y_i,
  output pipc_pkg::sts_t                         sts_o
);
  import pipc_pkg::*;

  logic [2*COORD_W-1:0] mem [MAX_VERTICES];
  logic [2*COORD_W-1:0] rd_o_q;
  logic [2*COORD_W-1:0] rd_a_q;

  logic signed [COORD_W-1:0] px_q;
  logic signed [COORD_W-1:0] py_q;

  logic signed [COORD_W-1:0] ox, oy, vax, vay;
  logic signed [DIFF_W-1:0]  ax, ay, bx, by;
  logic signed [PROD_W-1:0]  prod_l_q, prod_r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[cmd_i.wr_addr] <= {coord_y_i, coord_x_i};
    end
    rd_o_q <= mem[cmd_i.rd_o_addr];
    rd_a_q <= mem[cmd_i.rd_a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_load) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
  end

  // edge vector from the origin vertex and point vector from it
  assign ox  = rd_o_q[COORD_W-1:0];
  assign oy  = rd_o_q[2*COORD_W-1:COORD_W];
  assign vax = rd_a_q[COORD_W-1:0];
  assign vay = rd_a_q[2*COORD_W-1:COORD_W];

  assign ax = DIFF_W'(vax) - DIFF_W'(ox);
  assign ay = DIFF_W'(vay) - DIFF_W'(oy);
  assign bx = DIFF_W'(px_q) - DIFF_W'(ox);
  assign by = DIFF_W'(py_q) - DIFF_W'(oy);

  always_ff @(posedge clk_i) begin
    prod_l_q <= PROD_W'(ax) * PROD_W'(by);
    prod_r_q <= PROD_W'(ay) * PROD_W'(bx);
  end

  // sign of the cross product
  assign sts_o.cross_neg = prod_l_q < prod_r_q;
  assign sts_o.cross_pos = prod_l_q > prod_r_q;

endmodule

// File: rtl/pipc_ctrl.sv
`timescale 1ns / 1ps
module pipc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_func_i,
  input  logic [pipc_pkg::ADDR_W-1:0]    in_index_i,
  output logic                           in_ready_o,
  input  logic                           cfg_valid_i,
  input  logic [pipc_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           out_res_o,
  output pipc_pkg::cmd_t                 cmd_o,
  input  pipc_pkg::sts_t                 sts_i
);
  import pipc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] PH_WEDGE_LO = 2'd0;
  localparam logic [1:0] PH_WEDGE_HI = 2'd1;
  localparam logic [1:0] PH_SEARCH   = 2'd2;
  localparam logic [1:0] PH_EDGE     = 2'd3;

  logic [2:0]        state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [ADDR_W-1:0] lo_q, lo_d;
  logic [ADDR_W-1:0] hi_q, hi_d;
  logic              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic              out_res_q, out_res_d;
  logic [CNT_W-1:0]  count_q;

  logic [CNT_W-1:0]  n_eff;
  logic [ADDR_W:0]   mid_sum;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] nlo, nhi;
  logic              accept;

  assign n_eff   = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[ADDR_W:1];
  assign nlo     = sts_i.cross_neg ? lo_q : mid;
  assign nhi     = sts_i.cross_neg ? mid : hi_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_comb begin
    cmd_o.mem_we  = accept && (in_func_i == FUNC_WRITE);
    cmd_o.wr_addr = in_index_i;
    cmd_o.pt_load = accept && (in_func_i == FUNC_QUERY);
    unique case (phase_q)
      PH_WEDGE_LO: begin
        cmd_o.rd_o_addr = '0;
        cmd_o.rd_a_addr = ADDR_W'(1);
      end
      PH_WEDGE_HI: begin
        cmd_o.rd_o_addr = '0;
        cmd_o.rd_a_addr = hi_q;
      end
      PH_SEARCH: begin
        cmd_o.rd_o_addr = '0;
        cmd_o.rd_a_addr = mid;
      end
      default: begin
        cmd_o.rd_o_addr = lo_q;
        cmd_o.rd_a_addr = hi_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_func_i == FUNC_QUERY)) begin
          phase_d = PH_WEDGE_LO;
          lo_d    = ADDR_W'(1);
          hi_d    = ADDR_W'(n_eff - CNT_W'(1));
          if (n_eff < CNT_W'(MIN_POLY)) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_RD;
        unique case (phase_q)
          PH_WEDGE_LO: begin
            if (sts_i.cross_neg) begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end else begin
              phase_d = PH_WEDGE_HI;
            end
          end
          PH_WEDGE_HI: begin
            if (sts_i.cross_pos) begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end else begin
              phase_d = ((hi_q - lo_q) > ADDR_W'(1)) ? PH_SEARCH : PH_EDGE;
            end
          end
          PH_SEARCH: begin
            lo_d    = nlo;
            hi_d    = nhi;
            phase_d = ((nhi - nlo) > ADDR_W'(1)) ? PH_SEARCH : PH_EDGE;
          end
          default: begin
            res_d   = !sts_i.cross_neg;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_WEDGE_LO;
      lo_q        <= '0;
      hi_q        <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  a_search_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && phase_q == PH_SEARCH) |-> (hi_q - lo_q) > ADDR_W'(1))
    else $error("search window collapsed");

  a_lo_below_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && (phase_q == PH_SEARCH || phase_q == PH_EDGE)) |-> lo_q < hi_q)
    else $error("search bounds crossed");

  a_edge_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && phase_q == PH_EDGE) |=> state_q == ST_DONE)
    else $error("edge test did not finish the query");

  a_small_poly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_func_i == FUNC_QUERY && n_eff < CNT_W'(MIN_POLY))
      |=> (state_q == ST_DONE && !res_q))
    else $error("small polygon query not answered outside");

endmodule

// File: rtl/point_in_convex_polygon.sv
`timescale 1ns / 1ps
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: func; tdata: vertex_index, coord_x, coord_y
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: inside_res
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i: vertex_count
//
// a vertex write gives no response
// a query does one read, one multiply, one compare per cross product (ST_RD, ST_MUL, ST_EVAL):
// 2 wedge tests, up to 8 search steps for 256 vertices and one edge test,
// then ST_DONE hands over the response and ST_IDLE takes the next request;
// fewer than three vertices: ST_IDLE goes straight to ST_DONE and answers outside
// the response waits in an output register, so a stalled m_axis blocks requests only
// once the next query is done
// reset clears the controller and vertex_count; the vertex store is not cleared
module point_in_convex_polygon (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [71:0]                  s_axis_tdata,  // vertex_index, coord_x, coord_y, zero pad
  input  logic [0:0]                   s_axis_tuser,  // func
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // inside_res, zero pad
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pipc_pkg::CNT_W-1:0]   cfg_data_i
);
  import pipc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_res;

  logic [ADDR_W-1:0]         in_index;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;

  assign in_index = s_axis_tdata[ADDR_W-1:0];
  assign in_x     = s_axis_tdata[8+COORD_W-1:8];
  assign in_y     = s_axis_tdata[8+2*COORD_W-1:8+COORD_W];

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {7'd0, out_res};

  pipc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser[0]),
    .in_index_i  (in_index),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pipc_dp u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .coord_x_i (in_x),
    .coord_y_i (in_y),
    .sts_o     (sts)
  );

endmodule
